// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on clk, disabled while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form of the above
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmm_pkg.sv =====
// shared types, codes and helpers of the bank mapper
// no dependencies
package bmm_pkg;

    localparam int MAX_PRG_BANKS_DEF = 256;
    localparam int MAX_CHR_BANKS_DEF = 256;

    localparam int COUNT_W   = 9;
    localparam int BANK_W    = 8;
    localparam int LOW_W     = 13;
    localparam int OFFSET_W  = 21;
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STEPS = BANK_W / BITS_PER_STEP;

    localparam logic [2:0] KIND_CPU_WR   = 3'd0;
    localparam logic [2:0] KIND_CPU_RD   = 3'd1;
    localparam logic [2:0] KIND_PPU_RD   = 3'd2;
    localparam logic [2:0] KIND_PPU_WR   = 3'd3;
    localparam logic [2:0] KIND_PPU_ADDR = 3'd4;
    localparam logic [2:0] KIND_TICK     = 3'd5;

    localparam logic [1:0] REGION_NONE    = 2'd0;
    localparam logic [1:0] REGION_PRG_ROM = 2'd1;
    localparam logic [1:0] REGION_PRG_RAM = 2'd2;
    localparam logic [1:0] REGION_CHR     = 2'd3;

    localparam logic [1:0] MIRROR_HORZ = 2'd0;
    localparam logic [1:0] MIRROR_VERT = 2'd1;
    localparam logic [1:0] MIRROR_FOUR = 2'd2;

    localparam logic [2:0] CFG_PRG_COUNT = 3'd0;
    localparam logic [2:0] CFG_CHR_COUNT = 3'd1;
    localparam logic [2:0] CFG_CHR_RAM   = 3'd2;
    localparam logic [2:0] CFG_FOUR_SCR  = 3'd3;
    localparam logic [2:0] CFG_BATTERY   = 3'd4;

    typedef struct packed {
        logic [1:0]         region;
        logic [BANK_W-1:0]  bank;
        logic [COUNT_W-1:0] divisor;
        logic [LOW_W-1:0]   low;
        logic               strobe;
        logic               dirty;
        logic               irq;
        logic [1:0]         mirroring;
    } q_item_t;

    typedef struct packed {
        logic [1:0]          region;
        logic [OFFSET_W-1:0] offset;
        logic                strobe;
        logic                dirty;
        logic                irq;
        logic [1:0]          mirroring;
    } res_t;

    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] n,
                                                     input logic [COUNT_W-1:0] max);
        logic [COUNT_W-1:0] r;
        if (n == '0)
            r = COUNT_W'(1);
        else if (n > max)
            r = max;
        else
            r = n;
        return r;
    endfunction

endpackage

// ===== rtl/bmm_fifo.sv =====
// small register queue, generic width and depth
// no dependencies
module bmm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    output logic             is_full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rdata,
    output logic             is_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr, do_rd;

    assign is_full  = (cnt_reg == CW'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;
    assign rdata    = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == LAST) ? '0 : wptr_reg + PW'(1);
            if (do_rd)
                rptr_reg <= (rptr_reg == LAST) ? '0 : rptr_reg + PW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

// ===== rtl/bmm_front.sv =====
// front part: config, mapper registers, irq counter and item classification
// depends on bmm_pkg
module bmm_front #(
    parameter int MAX_PRG_BANKS = bmm_pkg::MAX_PRG_BANKS_DEF,
    parameter int MAX_CHR_BANKS = bmm_pkg::MAX_CHR_BANKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [8:0]            cfg_data,
    input  logic                  accept,
    input  logic [2:0]            kind,
    input  logic [15:0]           address,
    input  logic [7:0]            data,
    input  logic                  rendering_enabled,
    output bmm_pkg::q_item_t      item
);
    localparam logic [bmm_pkg::COUNT_W-1:0] MAXP = bmm_pkg::COUNT_W'(MAX_PRG_BANKS);
    localparam logic [bmm_pkg::COUNT_W-1:0] MAXC = bmm_pkg::COUNT_W'(MAX_CHR_BANKS);

    logic [8:0] prg_cnt_reg, chr_cnt_reg;
    logic       chr_ram_reg, four_reg, battery_reg;

    logic [7:0] bank_reg [8];
    logic [7:0] bank_next [8];
    logic [2:0] sel_reg, sel_next;
    logic       prg_mode_reg, prg_mode_next;
    logic       chr_mode_reg, chr_mode_next;
    logic       ram_en_reg, ram_en_next;
    logic       ram_prot_reg, ram_prot_next;
    logic       mirror_reg, mirror_next;
    logic [7:0] latch_reg, latch_next;
    logic [7:0] counter_reg, counter_next;
    logic       reload_reg, reload_next;
    logic       irq_en_reg, irq_en_next;
    logic       pending_reg, pending_next;
    logic       a12_reg, a12_next;

    logic [8:0] n8, n1;
    logic [7:0] second_last, last_bank, rom_win_bank, pat_win_bank;
    logic [2:0] win;
    logic [1:0] slot;
    logic       clock_counter;
    logic [7:0] cnt_tmp;

    always_comb
    begin
        n8 = bmm_pkg::eff_count(prg_cnt_reg, MAXP);
        n1 = bmm_pkg::eff_count(chr_cnt_reg, MAXC);
        second_last = (n8 == 9'd1) ? 8'd0 : 8'(n8 - 9'd2);
        last_bank   = 8'(n8 - 9'd1);
        slot = address[14:13];
        case (slot)
            2'd0:    rom_win_bank = prg_mode_reg ? second_last : bank_reg[6];
            2'd1:    rom_win_bank = bank_reg[7];
            2'd2:    rom_win_bank = prg_mode_reg ? bank_reg[6] : second_last;
            default: rom_win_bank = last_bank;
        endcase
        win = address[12:10] ^ {chr_mode_reg, 2'b00};
        case (win)
            3'd0:    pat_win_bank = bank_reg[0] & 8'hFE;
            3'd1:    pat_win_bank = bank_reg[0] | 8'h01;
            3'd2:    pat_win_bank = bank_reg[1] & 8'hFE;
            3'd3:    pat_win_bank = bank_reg[1] | 8'h01;
            default: pat_win_bank = bank_reg[3'(win - 3'd2)];
        endcase
    end

    always_comb
    begin
        bank_next     = bank_reg;
        sel_next      = sel_reg;
        prg_mode_next = prg_mode_reg;
        chr_mode_next = chr_mode_reg;
        ram_en_next   = ram_en_reg;
        ram_prot_next = ram_prot_reg;
        mirror_next   = mirror_reg;
        latch_next    = latch_reg;
        counter_next  = counter_reg;
        reload_next   = reload_reg;
        irq_en_next   = irq_en_reg;
        pending_next  = pending_reg;
        a12_next      = a12_reg;
        clock_counter = 1'b0;
        cnt_tmp       = '0;
        item          = '0;

        if (accept)
        begin
            case (kind)
                bmm_pkg::KIND_CPU_WR:
                begin
                    if (address[15])
                    begin
                        case (address[14:13])
                            2'd0:
                            begin
                                if (address[0])
                                    bank_next[sel_reg] = (sel_reg <= 3'd1) ? (data & 8'hFE)
                                                                           : data;
                                else
                                begin
                                    sel_next      = data[2:0];
                                    prg_mode_next = data[6];
                                    chr_mode_next = data[7];
                                end
                            end
                            2'd1:
                            begin
                                if (address[0])
                                begin
                                    ram_en_next   = data[7];
                                    ram_prot_next = data[6];
                                end
                                else if (!four_reg)
                                    mirror_next = !data[0];
                            end
                            2'd2:
                            begin
                                if (address[0])
                                begin
                                    counter_next = '0;
                                    reload_next  = 1'b1;
                                end
                                else
                                    latch_next = data;
                            end
                            default:
                            begin
                                irq_en_next = address[0];
                                if (!address[0])
                                    pending_next = 1'b0;
                            end
                        endcase
                    end
                    else if (address[14:13] == 2'b11 && ram_en_reg && !ram_prot_reg)
                    begin
                        item.region = bmm_pkg::REGION_PRG_RAM;
                        item.low    = address[12:0];
                        item.strobe = 1'b1;
                        item.dirty  = battery_reg;
                    end
                end
                bmm_pkg::KIND_CPU_RD:
                begin
                    if (address[15])
                    begin
                        item.region  = bmm_pkg::REGION_PRG_ROM;
                        item.bank    = rom_win_bank;
                        item.divisor = n8;
                        item.low     = address[12:0];
                    end
                    else if (address[14:13] == 2'b11 && ram_en_reg)
                    begin
                        item.region = bmm_pkg::REGION_PRG_RAM;
                        item.low    = address[12:0];
                    end
                end
                bmm_pkg::KIND_PPU_RD, bmm_pkg::KIND_PPU_WR:
                begin
                    if (kind == bmm_pkg::KIND_PPU_RD || chr_ram_reg)
                    begin
                        item.region  = bmm_pkg::REGION_CHR;
                        item.bank    = pat_win_bank;
                        item.divisor = n1;
                        item.low     = {3'b000, address[9:0]};
                        item.strobe  = (kind == bmm_pkg::KIND_PPU_WR);
                    end
                end
                bmm_pkg::KIND_PPU_ADDR:
                begin
                    clock_counter = address[12] && !a12_reg;
                    a12_next      = address[12];
                end
                bmm_pkg::KIND_TICK:
                    clock_counter = rendering_enabled;
                default:
                    clock_counter = 1'b0;
            endcase

            if (clock_counter)
            begin
                if (counter_reg == '0 || reload_reg)
                begin
                    cnt_tmp     = latch_reg;
                    reload_next = 1'b0;
                end
                else
                    cnt_tmp = counter_reg - 8'd1;
                counter_next = cnt_tmp;
                if (cnt_tmp == '0 && irq_en_reg)
                    pending_next = 1'b1;
            end

            item.irq       = pending_next;
            item.mirroring = four_reg ? bmm_pkg::MIRROR_FOUR
                           : (mirror_next ? bmm_pkg::MIRROR_VERT : bmm_pkg::MIRROR_HORZ);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_cnt_reg  <= 9'd4;
            chr_cnt_reg  <= 9'd8;
            chr_ram_reg  <= 1'b0;
            four_reg     <= 1'b0;
            battery_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
                bank_reg[i] <= (i == 7) ? 8'd1 : 8'd0;
            sel_reg      <= '0;
            prg_mode_reg <= 1'b0;
            chr_mode_reg <= 1'b0;
            ram_en_reg   <= 1'b1;
            ram_prot_reg <= 1'b0;
            mirror_reg   <= 1'b0;
            latch_reg    <= '0;
            counter_reg  <= '0;
            reload_reg   <= 1'b0;
            irq_en_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            a12_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bmm_pkg::CFG_PRG_COUNT: prg_cnt_reg <= cfg_data;
                    bmm_pkg::CFG_CHR_COUNT: chr_cnt_reg <= cfg_data;
                    bmm_pkg::CFG_CHR_RAM:   chr_ram_reg <= cfg_data[0];
                    bmm_pkg::CFG_FOUR_SCR:  four_reg    <= cfg_data[0];
                    bmm_pkg::CFG_BATTERY:   battery_reg <= cfg_data[0];
                    default:                ;
                endcase
            end
            bank_reg     <= bank_next;
            sel_reg      <= sel_next;
            prg_mode_reg <= prg_mode_next;
            chr_mode_reg <= chr_mode_next;
            ram_en_reg   <= ram_en_next;
            ram_prot_reg <= ram_prot_next;
            mirror_reg   <= mirror_next;
            latch_reg    <= latch_next;
            counter_reg  <= counter_next;
            reload_reg   <= reload_next;
            irq_en_reg   <= irq_en_next;
            pending_reg  <= pending_next;
            a12_reg      <= a12_next;
        end
    end

endmodule

// ===== rtl/bmm_back.sv =====
// back part: bank reduction by the configured count and offset assembly
// depends on bmm_pkg
module bmm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  bmm_pkg::q_item_t  q_item,
    output logic              q_pop,
    input  logic              o_full,
    output logic              o_push,
    output bmm_pkg::res_t     o_res
);
    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

    localparam int SW = $clog2(bmm_pkg::DIV_STEPS);
    localparam logic [SW-1:0] LAST_STEP = SW'(bmm_pkg::DIV_STEPS - 1);

    state_t                        state_reg;
    logic [SW-1:0]                 step_reg;
    logic [bmm_pkg::BANK_W-1:0]    div_reg;
    logic [bmm_pkg::BANK_W-1:0]    rem_reg;
    bmm_pkg::q_item_t              item_reg;

    logic                          need_div;
    logic [bmm_pkg::BANK_W:0]      r1, r2;
    logic [bmm_pkg::BANK_W-1:0]    rem_next;

    assign need_div = (q_item.region == bmm_pkg::REGION_PRG_ROM)
                   || (q_item.region == bmm_pkg::REGION_CHR);

    always_comb
    begin
        // two restoring remainder steps per cycle
        r1 = {rem_reg, div_reg[bmm_pkg::BANK_W-1]};
        if (r1 >= item_reg.divisor)
            r1 = r1 - item_reg.divisor;
        r2 = {r1[bmm_pkg::BANK_W-1:0], div_reg[bmm_pkg::BANK_W-2]};
        if (r2 >= item_reg.divisor)
            r2 = r2 - item_reg.divisor;
        rem_next = r2[bmm_pkg::BANK_W-1:0];
    end

    always_comb
    begin
        q_pop  = (state_reg == ST_IDLE) && !q_empty && (need_div || !o_full);
        o_push = 1'b0;
        o_res  = '0;
        if (state_reg == ST_IDLE)
        begin
            o_push          = !q_empty && !need_div && !o_full;
            o_res.region    = q_item.region;
            o_res.offset    = bmm_pkg::OFFSET_W'(q_item.low);
            o_res.strobe    = q_item.strobe;
            o_res.dirty     = q_item.dirty;
            o_res.irq       = q_item.irq;
            o_res.mirroring = q_item.mirroring;
        end
        else if (state_reg == ST_FIN)
        begin
            o_push          = !o_full;
            o_res.region    = item_reg.region;
            if (item_reg.region == bmm_pkg::REGION_PRG_ROM)
                o_res.offset = {rem_reg, item_reg.low};
            else
                o_res.offset = {3'b000, rem_reg, item_reg.low[9:0]};
            o_res.strobe    = item_reg.strobe;
            o_res.dirty     = item_reg.dirty;
            o_res.irq       = item_reg.irq;
            o_res.mirroring = item_reg.mirroring;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            div_reg   <= '0;
            rem_reg   <= '0;
            item_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty && need_div)
                    begin
                        item_reg  <= q_item;
                        div_reg   <= q_item.bank;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_next;
                    div_reg  <= div_reg << bmm_pkg::BITS_PER_STEP;
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == LAST_STEP)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!o_full)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/banked_memory_mapper_scanline_irq.sv =====
// rom and chr items pass from the input queue through the remainder unit of bmm_back (2
// bits per cycle against the bank count) to the output queue; it takes no new item until
// done with one; others pass one per cycle while it idles and the output queue has room
// reset: mapper registers, irq counter and config to power-on values, queues empty
// top level of the bank mapper; depends on bmm_pkg, bmm_fifo, bmm_front, bmm_back
module banked_memory_mapper_scanline_irq #(
    parameter int MAX_PRG_BANKS = bmm_pkg::MAX_PRG_BANKS_DEF,
    parameter int MAX_CHR_BANKS = bmm_pkg::MAX_CHR_BANKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  kind,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic        rendering_enabled,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  region,
    output logic [20:0] mapped_offset,
    output logic        write_strobe,
    output logic        save_dirty,
    output logic        irq_level,
    output logic [1:0]  mirroring
);
    bmm_pkg::q_item_t q_wdata, q_rdata;
    bmm_pkg::res_t    o_wdata, o_rdata;
    logic             q_full, q_empty, q_pop, o_full, o_push, accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    bmm_front #(
        .MAX_PRG_BANKS (MAX_PRG_BANKS),
        .MAX_CHR_BANKS (MAX_CHR_BANKS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .accept            (accept),
        .kind              (kind),
        .address           (address),
        .data              (data),
        .rendering_enabled (rendering_enabled),
        .item              (q_wdata)
    );

    bmm_fifo #(
        .WIDTH ($bits(bmm_pkg::q_item_t)),
        .DEPTH (2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wdata    (q_wdata),
        .is_full  (q_full),
        .rd_en    (q_pop),
        .rdata    (q_rdata),
        .is_empty (q_empty)
    );

    bmm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (q_rdata),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_res   (o_wdata)
    );

    bmm_fifo #(
        .WIDTH ($bits(bmm_pkg::res_t)),
        .DEPTH (2)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (o_push),
        .wdata    (o_wdata),
        .is_full  (o_full),
        .rd_en    (pop),
        .rdata    (o_rdata),
        .is_empty (empty)
    );

    assign region        = o_rdata.region;
    assign mapped_offset = o_rdata.offset;
    assign write_strobe  = o_rdata.strobe;
    assign save_dirty    = o_rdata.dirty;
    assign irq_level     = o_rdata.irq;
    assign mirroring     = o_rdata.mirroring;

endmodule

// ===== rtl/bmm_checker.sv =====
// port-level checker of the bank mapper, bound to the top level
// depends on bmm_pkg and assert_macros.svh
`include "assert_macros.svh"

module bmm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  region,
    input logic [20:0] mapped_offset,
    input logic        write_strobe,
    input logic        save_dirty,
    input logic        irq_level,
    input logic [1:0]  mirroring
);

    `ASSERT_IMPL(a_none_clean, !empty && region == bmm_pkg::REGION_NONE,
        mapped_offset == '0 && !write_strobe && !save_dirty,
        "open bus item carries offset or strobe")

    `ASSERT_IMPL(a_dirty_ram, !empty && save_dirty,
        write_strobe && region == bmm_pkg::REGION_PRG_RAM,
        "save_dirty outside a program ram write")

    `ASSERT_IMPL(a_rom_ro, !empty && region == bmm_pkg::REGION_PRG_ROM,
        !write_strobe && !save_dirty, "program rom item with write strobe")

    `ASSERT_IMPL(a_mirror_code, !empty, mirroring != 2'd3, "undefined mirroring code")

    `ASSERT_CLK(a_hold, (!empty && !pop) |=>
        (!empty && $stable(mapped_offset) && $stable(irq_level)), "waiting item changed")

endmodule

bind banked_memory_mapper_scanline_irq bmm_checker u_bmm_checker (.*);

// ===== dv/banked_memory_mapper_scanline_irq_test.sv =====
// self-checking testbench for the bank mapper with scanline irq counter
// runs a directed table, then random bursts under several bank settings, checked by a predictor
// depends on bmm_pkg and banked_memory_mapper_scanline_irq
`timescale 1ns / 1ps

module banked_memory_mapper_scanline_irq_test;

    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int unsigned MAX_PRG = bmm_pkg::MAX_PRG_BANKS_DEF;
    localparam int unsigned MAX_CHR = bmm_pkg::MAX_CHR_BANKS_DEF;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [1:0]  region;
        logic [20:0] offset;
        logic        strobe;
        logic        dirty;
        logic        irq;
        logic [1:0]  mirroring;
    } map_result_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        rend;
        logic        typed;
        map_result_t res;
    } stim_row_t;

    typedef struct packed {
        logic [8:0] prg;
        logic [8:0] chr;
        logic       chr_ram;
        logic       four;
        logic       batt;
    } mapper_cfg_t;

    localparam map_result_t R_NONE = '{bmm_pkg::REGION_NONE, 21'h0, 1'b0, 1'b0, 1'b0,
                                       bmm_pkg::MIRROR_HORZ};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        push;
    logic        full;
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic        rendering_enabled;
    logic        empty;
    logic        pop;
    logic [1:0]  region;
    logic [20:0] mapped_offset;
    logic        write_strobe;
    logic        save_dirty;
    logic        irq_level;
    logic [1:0]  mirroring;

    // predictor state
    logic [8:0] rom_count_cfg;
    logic [8:0] pat_count_cfg;
    logic       chr_writable;
    logic       four_screen_cfg;
    logic       battery_cfg;
    logic [7:0] bank_file [8];
    logic [2:0] sel_reg;
    logic       prg_swap;
    logic       chr_swap;
    logic       wram_on;
    logic       wram_locked;
    logic       mirror_vert;
    logic [7:0] irq_reload_val;
    logic [7:0] irq_count;
    logic       irq_reload_pending;
    logic       irq_armed;
    logic       irq_flag;
    logic       a12_prev;

    map_result_t awaiting_maps [$];
    mapper_cfg_t phase_cfgs [$] = '{
        '{9'd0,   9'd0,   1'b1, 1'b1, 1'b1},
        '{9'd256, 9'd256, 1'b0, 1'b0, 1'b1},
        '{9'd511, 9'd511, 1'b1, 1'b0, 1'b0},
        '{9'd1,   9'd1,   1'b0, 1'b1, 1'b0},
        '{9'd2,   9'd8,   1'b1, 1'b0, 1'b1},
        '{9'd3,   9'd255, 1'b0, 1'b0, 1'b0}
    };

    stim_row_t directed_rows [$] = '{
        '{bmm_pkg::KIND_CPU_RD, 16'h8000, 8'h00, 1'b0, 1'b1,
          '{bmm_pkg::REGION_PRG_ROM, 21'h00000, 1'b0, 1'b0, 1'b0, bmm_pkg::MIRROR_HORZ}},
        '{bmm_pkg::KIND_CPU_RD, 16'hFFFF, 8'h00, 1'b0, 1'b1,
          '{bmm_pkg::REGION_PRG_ROM, 21'h07FFF, 1'b0, 1'b0, 1'b0, bmm_pkg::MIRROR_HORZ}},
        '{bmm_pkg::KIND_CPU_RD, 16'h5FFF, 8'h00, 1'b1, 1'b1, R_NONE},
        '{bmm_pkg::KIND_CPU_WR, 16'h6000, 8'hAA, 1'b0, 1'b1,
          '{bmm_pkg::REGION_PRG_RAM, 21'h00000, 1'b1, 1'b0, 1'b0, bmm_pkg::MIRROR_HORZ}},
        '{bmm_pkg::KIND_CPU_RD, 16'h7FFF, 8'h00, 1'b0, 1'b1,
          '{bmm_pkg::REGION_PRG_RAM, 21'h01FFF, 1'b0, 1'b0, 1'b0, bmm_pkg::MIRROR_HORZ}},
        '{bmm_pkg::KIND_PPU_RD, 16'h0000, 8'h00, 1'b0, 1'b1,
          '{bmm_pkg::REGION_CHR, 21'h00000, 1'b0, 1'b0, 1'b0, bmm_pkg::MIRROR_HORZ}},
        '{bmm_pkg::KIND_PPU_RD, 16'hFFFF, 8'h00, 1'b0, 1'b1,
          '{bmm_pkg::REGION_CHR, 21'h003FF, 1'b0, 1'b0, 1'b0, bmm_pkg::MIRROR_HORZ}},
        '{bmm_pkg::KIND_PPU_WR, 16'h0400, 8'h5A, 1'b0, 1'b1, R_NONE},
        '{KIND_SPARE_LO, 16'hFFFF, 8'hFF, 1'b1, 1'b1, R_NONE},
        '{KIND_SPARE_HI, 16'h6000, 8'h12, 1'b1, 1'b1, R_NONE},
        '{bmm_pkg::KIND_CPU_WR, 16'h8000, 8'hC7, 1'b0, 1'b1, R_NONE},
        '{bmm_pkg::KIND_CPU_WR, 16'h9FFF, 8'hFF, 1'b0, 1'b1, R_NONE},
        '{bmm_pkg::KIND_CPU_RD, 16'h8000, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_PPU_RD, 16'h1000, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_WR, 16'hBFFE, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_WR, 16'hA001, 8'hC0, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_WR, 16'h6001, 8'h55, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_WR, 16'hA001, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_RD, 16'h6001, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_WR, 16'hC000, 8'h02, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_WR, 16'hDFFF, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_WR, 16'hE001, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_PPU_ADDR, 16'h1000, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_PPU_ADDR, 16'h0FFF, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_PPU_ADDR, 16'h1000, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_TICK, 16'h0000, 8'h00, 1'b1, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_WR, 16'hFFFE, 8'h00, 1'b0, 1'b0, '0},
        '{bmm_pkg::KIND_CPU_WR, 16'hA001, 8'h80, 1'b0, 1'b0, '0}
    };

    int  fail_count;
    int  items_sent;
    int  results_checked;
    int  full_cycles;
    int  settings_used;
    bit  sender_calm;
    bit  receiver_calm;
    bit  hold_req;

    banked_memory_mapper_scanline_irq uut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && push && full)
            full_cycles++;
    end

    function automatic int unsigned bank_limit(input logic [8:0] n, input int unsigned lim);
        if (n == 9'd0)
            return 1;
        return (n > lim) ? lim : n;
    endfunction

    function automatic logic [20:0] prg_window(input logic [15:0] a);
        int unsigned n;
        int unsigned bank;
        n = bank_limit(rom_count_cfg, MAX_PRG);
        case (a[14:13])
            2'd0: bank = prg_swap ? (2 * n - 2) % n : bank_file[6];
            2'd1: bank = bank_file[7];
            2'd2: bank = prg_swap ? bank_file[6] : (2 * n - 2) % n;
            default: bank = n - 1;
        endcase
        bank = bank % n;
        return 21'(bank * 32'h2000 + a[12:0]);
    endfunction

    function automatic logic [20:0] chr_window(input logic [15:0] a);
        int unsigned n;
        int unsigned bank;
        logic [2:0] win;
        n = bank_limit(pat_count_cfg, MAX_CHR);
        win = a[12:10] ^ {chr_swap, 2'b00};
        case (win)
            3'd0: bank = bank_file[0] & 8'hFE;
            3'd1: bank = bank_file[0] | 8'h01;
            3'd2: bank = bank_file[1] & 8'hFE;
            3'd3: bank = bank_file[1] | 8'h01;
            default: bank = bank_file[win - 3'd2];
        endcase
        bank = bank % n;
        return 21'(bank * 32'h400 + a[9:0]);
    endfunction

    function automatic void clock_scanline_counter();
        if (irq_count == 8'd0 || irq_reload_pending)
        begin
            irq_count = irq_reload_val;
            irq_reload_pending = 1'b0;
        end
        else
        begin
            irq_count = irq_count - 8'd1;
        end
        if (irq_count == 8'd0 && irq_armed)
            irq_flag = 1'b1;
    endfunction

    function automatic map_result_t map_bus_event(input logic [2:0] k, input logic [15:0] a,
                                                  input logic [7:0] d, input logic r);
        map_result_t res;
        res = '0;
        case (k)
            bmm_pkg::KIND_CPU_WR:
            begin
                if (a >= 16'h8000)
                begin
                    if (a < 16'hA000)
                    begin
                        if (a[0])
                            bank_file[sel_reg] = (sel_reg <= 3'd1) ? (d & 8'hFE) : d;
                        else
                        begin
                            sel_reg = d[2:0];
                            prg_swap = d[6];
                            chr_swap = d[7];
                        end
                    end
                    else if (a < 16'hC000)
                    begin
                        if (a[0])
                        begin
                            wram_on = d[7];
                            wram_locked = d[6];
                        end
                        else if (!four_screen_cfg)
                            mirror_vert = ~d[0];
                    end
                    else if (a < 16'hE000)
                    begin
                        if (a[0])
                        begin
                            irq_count = 8'd0;
                            irq_reload_pending = 1'b1;
                        end
                        else
                            irq_reload_val = d;
                    end
                    else
                    begin
                        irq_armed = a[0];
                        if (!a[0])
                            irq_flag = 1'b0;
                    end
                end
                else if (a >= 16'h6000 && wram_on && !wram_locked)
                begin
                    res.region = bmm_pkg::REGION_PRG_RAM;
                    res.offset = 21'(a - 16'h6000);
                    res.strobe = 1'b1;
                    res.dirty = battery_cfg;
                end
            end
            bmm_pkg::KIND_CPU_RD:
            begin
                if (a >= 16'h8000)
                begin
                    res.region = bmm_pkg::REGION_PRG_ROM;
                    res.offset = prg_window(a);
                end
                else if (a >= 16'h6000 && wram_on)
                begin
                    res.region = bmm_pkg::REGION_PRG_RAM;
                    res.offset = 21'(a - 16'h6000);
                end
            end
            bmm_pkg::KIND_PPU_RD:
            begin
                res.region = bmm_pkg::REGION_CHR;
                res.offset = chr_window(a);
            end
            bmm_pkg::KIND_PPU_WR:
            begin
                if (chr_writable)
                begin
                    res.region = bmm_pkg::REGION_CHR;
                    res.offset = chr_window(a);
                    res.strobe = 1'b1;
                end
            end
            bmm_pkg::KIND_PPU_ADDR:
            begin
                if (a[12] && !a12_prev)
                    clock_scanline_counter();
                a12_prev = a[12];
            end
            bmm_pkg::KIND_TICK:
            begin
                if (r)
                    clock_scanline_counter();
            end
            default:
            begin
            end
        endcase
        res.irq = irq_flag;
        res.mirroring = four_screen_cfg ? bmm_pkg::MIRROR_FOUR
                      : (mirror_vert ? bmm_pkg::MIRROR_VERT : bmm_pkg::MIRROR_HORZ);
        return res;
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic offer(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d,
                         input logic r, input logic use_typed = 1'b0,
                         input map_result_t typed_res = '0);
        int gap;
        map_result_t predicted;
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        kind <= k;
        address <= a;
        data <= d;
        rendering_enabled <= r;
        do @(posedge clk); while (full);
        predicted = map_bus_event(k, a, d, r);
        awaiting_maps.push_back(use_typed ? typed_res : predicted);
        if (k < KIND_SPARE_LO)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (awaiting_maps.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_config(input mapper_cfg_t c);
        cfg_we <= 1'b1;
        cfg_index <= bmm_pkg::CFG_PRG_COUNT;
        cfg_data <= c.prg;
        @(negedge clk);
        cfg_index <= bmm_pkg::CFG_CHR_COUNT;
        cfg_data <= c.chr;
        @(negedge clk);
        cfg_index <= bmm_pkg::CFG_CHR_RAM;
        cfg_data <= {8'($urandom), c.chr_ram};
        @(negedge clk);
        cfg_index <= bmm_pkg::CFG_FOUR_SCR;
        cfg_data <= {8'($urandom), c.four};
        @(negedge clk);
        cfg_index <= bmm_pkg::CFG_BATTERY;
        cfg_data <= {8'($urandom), c.batt};
        @(negedge clk);
        cfg_we <= 1'b0;
        rom_count_cfg = c.prg;
        pat_count_cfg = c.chr;
        chr_writable = c.chr_ram;
        four_screen_cfg = c.four;
        battery_cfg = c.batt;
        settings_used++;
    endtask

    task automatic run_random(input int quota, input bit with_hold);
        int start;
        int pick;
        int n;
        bit held;
        start = items_sent;
        held = 1'b0;
        while (items_sent - start < quota)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                sender_calm = ($urandom_range(0, 2) == 0);
                receiver_calm = ($urandom_range(0, 2) == 0);
            end
            if (with_hold && !held && items_sent - start > quota / 3)
            begin
                hold_req = 1'b1;
                sender_calm = 1'b1;
                held = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                // noise
                offer(3'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
            end
            else if (pick < 40)
            begin
                // bank select and bank data, then accesses through the windows
                offer(bmm_pkg::KIND_CPU_WR, {3'b100, 12'($urandom), 1'b0}, 8'($urandom),
                      1'($urandom));
                offer(bmm_pkg::KIND_CPU_WR, {3'b100, 12'($urandom), 1'b1}, 8'($urandom),
                      1'($urandom));
                repeat (3)
                begin
                    case ($urandom_range(0, 2))
                        0: offer(bmm_pkg::KIND_CPU_RD, {1'b1, 15'($urandom)}, 8'($urandom),
                                 1'($urandom));
                        1: offer(bmm_pkg::KIND_PPU_RD, 16'($urandom), 8'($urandom),
                                 1'($urandom));
                        default: offer(bmm_pkg::KIND_PPU_WR, 16'($urandom), 8'($urandom),
                                       1'($urandom));
                    endcase
                end
            end
            else if (pick < 65)
            begin
                // irq latch, reload and enable or disable, then a run of counter clocks
                offer(bmm_pkg::KIND_CPU_WR, {3'b110, 12'($urandom), 1'b0},
                      8'($urandom_range(0, 5)), 1'($urandom));
                offer(bmm_pkg::KIND_CPU_WR, {3'b110, 12'($urandom), 1'b1}, 8'($urandom),
                      1'($urandom));
                offer(bmm_pkg::KIND_CPU_WR,
                      {3'b111, 12'($urandom), 1'($urandom_range(0, 3) != 0)},
                      8'($urandom), 1'($urandom));
                n = $urandom_range(4, 16);
                repeat (n)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        offer(bmm_pkg::KIND_PPU_ADDR, {3'($urandom), 1'b0, 12'($urandom)},
                              8'($urandom), 1'($urandom));
                        offer(bmm_pkg::KIND_PPU_ADDR, {3'($urandom), 1'b1, 12'($urandom)},
                              8'($urandom), 1'($urandom));
                    end
                    else
                        offer(bmm_pkg::KIND_TICK, 16'($urandom), 8'($urandom),
                              1'($urandom_range(0, 3) != 0));
                    if ($urandom_range(0, 7) == 0)
                        offer(bmm_pkg::KIND_CPU_WR, {3'b111, 12'($urandom), 1'($urandom)},
                              8'($urandom), 1'($urandom));
                end
            end
            else if (pick < 80)
            begin
                // ram guard bits and mirroring, then ram traffic
                offer(bmm_pkg::KIND_CPU_WR, {3'b101, 12'($urandom), 1'b1},
                      {1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 3) == 0),
                       6'($urandom)}, 1'($urandom));
                if ($urandom_range(0, 1) == 1)
                    offer(bmm_pkg::KIND_CPU_WR, {3'b101, 12'($urandom), 1'b0}, 8'($urandom),
                          1'($urandom));
                repeat (3)
                    offer($urandom_range(0, 1) ? bmm_pkg::KIND_CPU_WR : bmm_pkg::KIND_CPU_RD,
                          16'($urandom_range(16'h5000, 16'h7FFF)), 8'($urandom), 1'($urandom));
            end
            else
            begin
                offer(bmm_pkg::KIND_CPU_RD, 16'($urandom), 8'($urandom), 1'($urandom));
                offer(bmm_pkg::KIND_PPU_RD, 16'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // result side
    initial
    begin
        int stall;
        map_result_t want;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = receiver_calm ? 0 : $urandom_range(0, 4);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            if (awaiting_maps.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t ns: result with nothing expected, region 0x%0h offset 0x%0h",
                             $time, region, mapped_offset);
            end
            else
            begin
                want = awaiting_maps.pop_front();
                check_field("region", want.region, region);
                check_field("mapped_offset", want.offset, mapped_offset);
                check_field("write_strobe", want.strobe, write_strobe);
                check_field("save_dirty", want.dirty, save_dirty);
                check_field("irq_level", want.irq, irq_level);
                check_field("mirroring", want.mirroring, mirroring);
                results_checked++;
            end
        end
    end

    // item side
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = bmm_pkg::CFG_PRG_COUNT;
        cfg_data = 9'd0;
        push = 1'b0;
        kind = bmm_pkg::KIND_CPU_RD;
        address = 16'h0000;
        data = 8'h00;
        rendering_enabled = 1'b0;
        fail_count = 0;
        items_sent = 0;
        results_checked = 0;
        full_cycles = 0;
        settings_used = 1;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        hold_req = 1'b0;

        rom_count_cfg = 9'd4;
        pat_count_cfg = 9'd8;
        chr_writable = 1'b0;
        four_screen_cfg = 1'b0;
        battery_cfg = 1'b0;
        foreach (bank_file[i])
            bank_file[i] = 8'd0;
        bank_file[7] = 8'd1;
        sel_reg = 3'd0;
        prg_swap = 1'b0;
        chr_swap = 1'b0;
        wram_on = 1'b1;
        wram_locked = 1'b0;
        mirror_vert = 1'b0;
        irq_reload_val = 8'd0;
        irq_count = 8'd0;
        irq_reload_pending = 1'b0;
        irq_armed = 1'b0;
        irq_flag = 1'b0;
        a12_prev = 1'b0;

        phase_cfgs.push_back('{9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                               1'($urandom), 1'($urandom), 1'($urandom)});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].data,
                  directed_rows[i].rend, directed_rows[i].typed, directed_rows[i].res);
        run_random(ITEMS_PER_PHASE, 1'b0);

        foreach (phase_cfgs[p])
        begin
            settle();
            apply_config(phase_cfgs[p]);
            run_random(ITEMS_PER_PHASE, p == 1 || p == 4);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d items under %0d bank settings, %0d results checked",
                 items_sent, settings_used, results_checked);
        $display("run: input held off by full on %0d cycles, %0d mismatches",
                 full_cycles, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== banked_memory_mapper_scanline_irq.f =====
+incdir+rtl
rtl/bmm_pkg.sv
rtl/bmm_fifo.sv
rtl/bmm_front.sv
rtl/bmm_back.sv
rtl/banked_memory_mapper_scanline_irq.sv
rtl/bmm_checker.sv
dv/banked_memory_mapper_scanline_irq_test.sv
